// ----- src/smd_pkg.sv -----
// Shared types and constants for the sign-magnitude 96-bit divider.
`timescale 1ns / 1ps
package smd_pkg;

  // Magnitude geometry of the operands and the quotient.
  localparam int SMD_MAG_W  = 96;
  localparam int SMD_LOW_W  = 64;
  localparam int SMD_HIGH_W = SMD_MAG_W - SMD_LOW_W;

  // Default number of magnitude bits held by one cell of the chain.
  localparam int SMD_CELL_W = 8;

  // Status codes of a result.
  localparam logic SMD_STATUS_OK       = 1'b0;
  localparam logic SMD_STATUS_DIV_ZERO = 1'b1;

  // Sequencer states.
  typedef enum logic {
    SMD_IDLE,
    SMD_RUN
  } smd_state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;   // capture a new dividend and divisor, clear the remainder
    logic step;   // perform one shift-subtract iteration
    logic take;   // trial difference is non-negative: keep it, quotient bit is one
  } smd_cell_ctl_t;

endpackage

// ----- src/smd_in_if.sv -----
// Operand channel: valid/ready handshake carrying one sign-magnitude division request.
`timescale 1ns / 1ps
interface smd_in_if;
  logic                        valid;
  logic                        ready;
  logic [smd_pkg::SMD_LOW_W-1:0]  dividend_low;
  logic [smd_pkg::SMD_HIGH_W-1:0] dividend_high;
  logic                        dividend_negative;
  logic [smd_pkg::SMD_LOW_W-1:0]  divisor_low;
  logic [smd_pkg::SMD_HIGH_W-1:0] divisor_high;
  logic                        divisor_negative;

  modport source (
    output valid, dividend_low, dividend_high, dividend_negative,
           divisor_low, divisor_high, divisor_negative,
    input  ready
  );

  modport sink (
    input  valid, dividend_low, dividend_high, dividend_negative,
           divisor_low, divisor_high, divisor_negative,
    output ready
  );
endinterface

// ----- src/smd_out_if.sv -----
// Result channel: valid/ready handshake carrying one quotient and its status.
`timescale 1ns / 1ps
interface smd_out_if;
  logic                        valid;
  logic                        ready;
  logic [smd_pkg::SMD_LOW_W-1:0]  quotient_low;
  logic [smd_pkg::SMD_HIGH_W-1:0] quotient_high;
  logic                        quotient_negative;
  logic                        status;

  modport source (
    output valid, quotient_low, quotient_high, quotient_negative, status,
    input  ready
  );

  modport sink (
    input  valid, quotient_low, quotient_high, quotient_negative, status,
    output ready
  );
endinterface

// ----- src/smd_cell.sv -----
// One bit slice of the divider: remainder, dividend/quotient and divisor bits with a borrow link.
`timescale 1ns / 1ps
module smd_cell #(
  parameter int W = smd_pkg::SMD_CELL_W
) (
  input  logic                   clk,
  input  smd_pkg::smd_cell_ctl_t ctl,
  input  logic [W-1:0]           ld_dividend,
  input  logic [W-1:0]           ld_divisor,
  input  logic                   rem_lsb_in,
  input  logic                   dq_lsb_in,
  input  logic                   borrow_in,
  output logic                   rem_msb,
  output logic                   dq_msb,
  output logic                   borrow_out,
  output logic [W-1:0]           dq_shifted
);

  logic [W-1:0] rem;
  logic [W-1:0] dq;
  logic [W-1:0] div;
  logic [W-1:0] rem_shifted;
  logic [W:0]   diff;

  // The remainder slice shifts left, taking the top bit of the slice below.
  assign rem_shifted = {rem[W-2:0], rem_lsb_in};
  assign diff        = {1'b0, rem_shifted} - {1'b0, div} - {{W{1'b0}}, borrow_in};
  assign borrow_out  = diff[W];
  assign rem_msb     = rem[W-1];

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  assign dq_shifted  = {dq[W-2:0], dq_lsb_in};
  assign dq_msb      = dq[W-1];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= '0;
      dq  <= ld_dividend;
      div <= ld_divisor;
    end else if (ctl.step) begin
      rem <= ctl.take ? diff[W-1:0] : rem_shifted;
      dq  <= dq_shifted;
    end
  end

endmodule

// ----- src/sign_magnitude_96bit_divider.sv -----
// Top level of the sign-magnitude 96-bit restoring divider built from a chain of bit-slice cells.
// The cell chain produces one quotient bit per cycle, except when the final iteration
// waits for the output register; new operands are taken only once a division is done.
// The 96-bit trial subtraction ripples its borrow through all cells in each cycle.
// A finished result waits in an output register while the next operands are taken.
// Reset (rst, synchronous, active high) empties the sequencer and the output register.
`timescale 1ns / 1ps
module sign_magnitude_96bit_divider #(
  parameter int CELL_W = smd_pkg::SMD_CELL_W
) (
  input logic     clk,
  input logic     rst,
  smd_in_if.sink  operands,
  smd_out_if.source results
);

  localparam int MAG_W     = smd_pkg::SMD_MAG_W;
  localparam int LOW_W     = smd_pkg::SMD_LOW_W;
  localparam int NUM_CELLS = MAG_W / CELL_W;
  localparam int CNT_W     = $clog2(MAG_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);

  // Sequencer state.
  smd_pkg::smd_state_t state;
  smd_pkg::smd_state_t state_next;
  logic [CNT_W-1:0]    count;
  logic                advance;
  logic                last;
  logic                accept;

  // Per-item flags captured at the operand transfer.
  logic sign;
  logic div_zero;

  // Output register.
  logic                      out_valid;
  logic [MAG_W-1:0]          out_quotient;
  logic                      out_sign;
  logic                      out_status;

  // Cell chain wiring.
  smd_pkg::smd_cell_ctl_t ctl;
  logic [MAG_W-1:0]       ld_dividend;
  logic [MAG_W-1:0]       ld_divisor;
  logic [MAG_W-1:0]       q_next;
  logic [NUM_CELLS-1:0]   rem_msb;
  logic [NUM_CELLS-1:0]   dq_msb;
  logic [NUM_CELLS-1:0]   borrow;

  assign ld_dividend = {operands.dividend_high, operands.dividend_low};
  assign ld_divisor  = {operands.divisor_high, operands.divisor_low};

  // New operands are taken only between divisions; a pending result does not block them.
  assign operands.ready = (state == smd_pkg::SMD_IDLE);
  assign accept         = operands.valid && operands.ready;
  assign last           = (count == LAST_STEP);

  always_comb begin
    state_next = state;
    advance    = 1'b0;
    case (state)
      smd_pkg::SMD_IDLE: begin
        if (accept) begin
          state_next = smd_pkg::SMD_RUN;
        end
      end
      smd_pkg::SMD_RUN: begin
        // The final iteration waits until the output register can take its result.
        advance = !(last && out_valid && !results.ready);
        if (advance && last) begin
          state_next = smd_pkg::SMD_IDLE;
        end
      end
      default: begin
        state_next = smd_pkg::SMD_IDLE;
      end
    endcase
  end

  // The shifted 97-bit remainder is at least the divisor when its top bit is set,
  // or when the 96-bit trial subtraction leaves no borrow out of the top cell.
  assign ctl.load = accept;
  assign ctl.step = advance;
  assign ctl.take = rem_msb[NUM_CELLS-1] || !borrow[NUM_CELLS-1];

  generate
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      logic rem_in;
      logic dq_in;
      logic b_in;

      if (k == 0) begin : g_first
        // The bottom cell takes the next dividend bit and the new quotient bit.
        assign rem_in = dq_msb[NUM_CELLS-1];
        assign dq_in  = ctl.take;
        assign b_in   = 1'b0;
      end else begin : g_rest
        assign rem_in = rem_msb[k-1];
        assign dq_in  = dq_msb[k-1];
        assign b_in   = borrow[k-1];
      end

      smd_cell #(
        .W (CELL_W)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .ld_dividend (ld_dividend[k*CELL_W +: CELL_W]),
        .ld_divisor  (ld_divisor[k*CELL_W +: CELL_W]),
        .rem_lsb_in  (rem_in),
        .dq_lsb_in   (dq_in),
        .borrow_in   (b_in),
        .rem_msb     (rem_msb[k]),
        .dq_msb      (dq_msb[k]),
        .borrow_out  (borrow[k]),
        .dq_shifted  (q_next[k*CELL_W +: CELL_W])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smd_pkg::SMD_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= '0;
      end else if (advance) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sign     <= operands.dividend_negative ^ operands.divisor_negative;
      div_zero <= (ld_divisor == '0);
    end
  end

  // The quotient is captured straight from the last shift, so the chain is free at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last) begin
      // A zero divisor yields a zero magnitude but keeps the operand sign.
      out_quotient <= div_zero ? '0 : q_next;
      out_sign     <= sign;
      out_status   <= div_zero ? smd_pkg::SMD_STATUS_DIV_ZERO : smd_pkg::SMD_STATUS_OK;
    end
  end

  assign results.valid             = out_valid;
  assign results.quotient_low      = out_quotient[LOW_W-1:0];
  assign results.quotient_high     = out_quotient[MAG_W-1:LOW_W];
  assign results.quotient_negative = out_sign;
  assign results.status            = out_status;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the sign-magnitude 96-bit divider: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;

  // One division request as it travels on the operand channel.
  typedef struct packed {
    logic [smd_pkg::SMD_HIGH_W-1:0] dividend_high;
    logic [smd_pkg::SMD_LOW_W-1:0]  dividend_low;
    logic                           dividend_negative;
    logic [smd_pkg::SMD_HIGH_W-1:0] divisor_high;
    logic [smd_pkg::SMD_LOW_W-1:0]  divisor_low;
    logic                           divisor_negative;
  } division_request_t;

  // One quotient as it travels on the result channel.
  typedef struct packed {
    logic [smd_pkg::SMD_HIGH_W-1:0] quotient_high;
    logic [smd_pkg::SMD_LOW_W-1:0]  quotient_low;
    logic                           quotient_negative;
    logic                           status;
  } quotient_t;

  // A row of the directed table. Where the outcome is obvious it is typed in;
  // otherwise the row is checked against the bit-serial divider below.
  typedef struct {
    division_request_t req;
    bit                known;
    quotient_t         want;
  } directed_row_t;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // After the last result we wait out a drain period longer than one division
  // so that a stray extra transfer would still be seen.
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned IDLE_PERCENT = 36;

  localparam logic [smd_pkg::SMD_MAG_W-1:0]  MAG_ONES  = '1;
  localparam logic [smd_pkg::SMD_LOW_W-1:0]  LOW_ONES  = '1;
  localparam logic [smd_pkg::SMD_HIGH_W-1:0] HIGH_ONES = '1;
  localparam logic [smd_pkg::SMD_HIGH_W-1:0] HIGH_TOP  =
    {1'b1, {(smd_pkg::SMD_HIGH_W-1){1'b0}}};

  logic clk;
  logic rst;

  smd_in_if  operand_ch ();
  smd_out_if result_ch ();

  sign_magnitude_96bit_divider u_dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operand_ch),
    .results  (result_ch)
  );

  quotient_t       pending_quotients[$];
  directed_row_t   directed_rows[$];
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;
  // While this is set neither side of the bench inserts idle cycles, so the
  // block sees a long stretch of back-to-back traffic.
  bit              steady_phase;

  // Clock with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit-serial restoring division of the magnitudes. The partial remainder is
  // carried at 97 bits so that divisors at or above 2^95 still divide right.
  // The quotient sign is the XOR of the operand signs, even for a zero result
  // and even when the divisor is zero.
  function automatic quotient_t divide_sign_magnitude(input division_request_t req);
    logic [smd_pkg::SMD_MAG_W-1:0] dividend;
    logic [smd_pkg::SMD_MAG_W-1:0] divisor;
    logic [smd_pkg::SMD_MAG_W-1:0] quotient;
    logic [smd_pkg::SMD_MAG_W:0]   partial;
    quotient_t                     res;
    dividend = {req.dividend_high, req.dividend_low};
    divisor  = {req.divisor_high, req.divisor_low};
    quotient = '0;
    partial  = '0;
    res.quotient_negative = req.dividend_negative ^ req.divisor_negative;
    if (divisor == '0) begin
      res.status = smd_pkg::SMD_STATUS_DIV_ZERO;
    end else begin
      res.status = smd_pkg::SMD_STATUS_OK;
      for (int i = smd_pkg::SMD_MAG_W - 1; i >= 0; i--) begin
        partial  = {partial[smd_pkg::SMD_MAG_W-1:0], dividend[i]};
        quotient = quotient << 1;
        if (partial >= {1'b0, divisor}) begin
          partial     = partial - {1'b0, divisor};
          quotient[0] = 1'b1;
        end
      end
    end
    res.quotient_high = quotient[smd_pkg::SMD_MAG_W-1:smd_pkg::SMD_LOW_W];
    res.quotient_low  = quotient[smd_pkg::SMD_LOW_W-1:0];
    return res;
  endfunction

  // Random magnitude with a spread of sizes. Most values are truncated to a
  // random width so that quotients range from zero to nearly full width; the
  // rest are all ones, single powers of two, runs of ones and full-width noise.
  function automatic logic [smd_pkg::SMD_MAG_W-1:0] random_magnitude();
    logic [smd_pkg::SMD_MAG_W-1:0] raw;
    raw = {$urandom, $urandom, $urandom};
    case ($urandom_range(15))
      0:       raw = MAG_ONES;
      1:       raw = {{(smd_pkg::SMD_MAG_W-1){1'b0}}, 1'b1}
                     << $urandom_range(smd_pkg::SMD_MAG_W - 1);
      2:       raw = MAG_ONES >> $urandom_range(smd_pkg::SMD_MAG_W - 1);
      3, 4, 5: raw = raw;
      default: raw = raw >> $urandom_range(smd_pkg::SMD_MAG_W - 1);
    endcase
    return raw;
  endfunction

  function automatic division_request_t make_request(
    input logic [smd_pkg::SMD_HIGH_W-1:0] nh, input logic [smd_pkg::SMD_LOW_W-1:0] nl,
    input logic ns,
    input logic [smd_pkg::SMD_HIGH_W-1:0] dh, input logic [smd_pkg::SMD_LOW_W-1:0] dl,
    input logic ds);
    division_request_t req;
    req = '{nh, nl, ns, dh, dl, ds};
    return req;
  endfunction

  function automatic quotient_t make_quotient(
    input logic [smd_pkg::SMD_HIGH_W-1:0] qh, input logic [smd_pkg::SMD_LOW_W-1:0] ql,
    input logic qn, input logic st);
    quotient_t q;
    q = '{qh, ql, qn, st};
    return q;
  endfunction

  // Drives one request and waits for its transfer. Random idle cycles come
  // first; valid is only lowered in a step where it is not raised again.
  task automatic send_division(input division_request_t req, input quotient_t want);
    while (!steady_phase && $urandom_range(99) < IDLE_PERCENT) begin
      operand_ch.valid <= 1'b0;
      @(posedge clk);
    end
    operand_ch.valid             <= 1'b1;
    operand_ch.dividend_high     <= req.dividend_high;
    operand_ch.dividend_low      <= req.dividend_low;
    operand_ch.dividend_negative <= req.dividend_negative;
    operand_ch.divisor_high      <= req.divisor_high;
    operand_ch.divisor_low       <= req.divisor_low;
    operand_ch.divisor_negative  <= req.divisor_negative;
    // Values read right after the edge are the ones the block saw at it.
    do @(posedge clk); while (operand_ch.ready !== 1'b1);
    pending_quotients.push_back(want);
  endtask

  // Compares one transferred result with the oldest expectation.
  task automatic check_quotient(input quotient_t got);
    quotient_t want;
    if (pending_quotients.size() == 0) begin
      $error("result with no division pending: high %h low %h negative %b status %b",
             got.quotient_high, got.quotient_low, got.quotient_negative, got.status);
      error_count++;
      return;
    end
    want = pending_quotients.pop_front();
    if (got.quotient_high !== want.quotient_high) begin
      $error("quotient_high: expected %h, got %h", want.quotient_high, got.quotient_high);
      error_count++;
    end
    if (got.quotient_low !== want.quotient_low) begin
      $error("quotient_low: expected %h, got %h", want.quotient_low, got.quotient_low);
      error_count++;
    end
    if (got.quotient_negative !== want.quotient_negative) begin
      $error("quotient_negative: expected %b, got %b",
             want.quotient_negative, got.quotient_negative);
      error_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %b, got %b", want.status, got.status);
      error_count++;
    end
  endtask

  // Result side: check every transfer seen at the edge, then pick the next
  // value of ready. Ready stalls at random except in the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        check_quotient('{result_ch.quotient_high, result_ch.quotient_low,
                         result_ch.quotient_negative, result_ch.status});
      end
      result_ch.ready <= steady_phase || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Directed table: the zero-divisor case with every sign pair, negative zero
  // from a zero dividend, the largest and smallest magnitudes, divisors at and
  // above 2^95 where the remainder needs its extra bit, and a few patterns.
  initial begin
    directed_rows.push_back('{make_request('0, '0, 1'b0, '0, '0, 1'b0), 1'b1,
                              make_quotient('0, '0, 1'b0, smd_pkg::SMD_STATUS_DIV_ZERO)});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b1, '0, '0, 1'b0), 1'b1,
                              make_quotient('0, '0, 1'b1, smd_pkg::SMD_STATUS_DIV_ZERO)});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b0, '0, '0, 1'b1), 1'b1,
                              make_quotient('0, '0, 1'b1, smd_pkg::SMD_STATUS_DIV_ZERO)});
    directed_rows.push_back('{make_request('0, 64'd7, 1'b1, '0, '0, 1'b1), 1'b1,
                              make_quotient('0, '0, 1'b0, smd_pkg::SMD_STATUS_DIV_ZERO)});
    directed_rows.push_back('{make_request('0, '0, 1'b1, '0, 64'd1, 1'b0), 1'b1,
                              make_quotient('0, '0, 1'b1, smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request('0, '0, 1'b1, HIGH_ONES, LOW_ONES, 1'b1), 1'b1,
                              make_quotient('0, '0, 1'b0, smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b0, '0, 64'd1, 1'b0), 1'b1,
                              make_quotient(HIGH_ONES, LOW_ONES, 1'b0,
                                            smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b1, '0, 64'd1, 1'b0), 1'b1,
                              make_quotient(HIGH_ONES, LOW_ONES, 1'b1,
                                            smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b0, HIGH_ONES, LOW_ONES, 1'b1),
                              1'b1, make_quotient('0, 64'd1, 1'b1, smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request('0, 64'd1, 1'b0, HIGH_ONES, LOW_ONES, 1'b0), 1'b1,
                              make_quotient('0, '0, 1'b0, smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b0, HIGH_TOP, '0, 1'b0), 1'b1,
                              make_quotient('0, 64'd1, 1'b0, smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request(HIGH_TOP, '0, 1'b0, HIGH_TOP, '0, 1'b1), 1'b1,
                              make_quotient('0, 64'd1, 1'b1, smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request(HIGH_ONES >> 1, LOW_ONES, 1'b0, HIGH_TOP, '0, 1'b0),
                              1'b1, make_quotient('0, '0, 1'b0, smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request('0, 64'd1, 1'b1, '0, 64'd1, 1'b1), 1'b1,
                              make_quotient('0, 64'd1, 1'b0, smd_pkg::SMD_STATUS_OK)});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b0, HIGH_TOP, 64'd1, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b0, '0, 64'd2, 1'b1),
                              1'b0, '0});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b1, '0, 64'd3, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_request(32'd1, '0, 1'b0, '0, 64'h1_0000_0000, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_request(HIGH_ONES, '0, 1'b1, '0, LOW_ONES, 1'b1),
                              1'b0, '0});
    directed_rows.push_back('{make_request(HIGH_ONES, LOW_ONES, 1'b0, 32'd1, '0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_request(32'h5555_5555, 64'h5555_5555_5555_5555, 1'b1,
                                           32'h0, 64'hAAAA, 1'b0), 1'b0, '0});
    directed_rows.push_back('{make_request(32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF, 1'b0,
                                           32'h0000_0F0F, 64'hFEDC_BA98_7654_3210, 1'b1),
                              1'b0, '0});
  end

  // Stimulus: reset once, walk the directed table, then random divisions,
  // then drain and report.
  initial begin
    division_request_t req;
    quotient_t         want;
    rst                          = 1'b1;
    steady_phase                 = 1'b0;
    operand_ch.valid             <= 1'b0;
    operand_ch.dividend_high     <= '0;
    operand_ch.dividend_low      <= '0;
    operand_ch.dividend_negative <= 1'b0;
    operand_ch.divisor_high      <= '0;
    operand_ch.divisor_low       <= '0;
    operand_ch.divisor_negative  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      want = directed_rows[k].known ? directed_rows[k].want
                                    : divide_sign_magnitude(directed_rows[k].req);
      send_division(directed_rows[k].req, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_phase <= (n >= 700 && n < 1000);
      req.dividend_negative = 1'($urandom_range(1));
      req.divisor_negative  = 1'($urandom_range(1));
      {req.dividend_high, req.dividend_low} = random_magnitude();
      // A few percent of the divisors are zero to keep the error path busy.
      if ($urandom_range(99) < 4) begin
        {req.divisor_high, req.divisor_low} = '0;
      end else begin
        {req.divisor_high, req.divisor_low} = random_magnitude();
      end
      send_division(req, divide_sign_magnitude(req));
    end
    operand_ch.valid <= 1'b0;
    steady_phase     <= 1'b0;

    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
